// File: design/inorm_pkg.sv
`default_nettype none
package inorm_pkg;

    // Slice geometry
    localparam int SLICE_MAX = 64;
    localparam int ADDR_W    = (SLICE_MAX > 1) ? $clog2(SLICE_MAX) : 1;
    localparam int FILL_W    = $clog2(SLICE_MAX + 1);

    // Field widths
    localparam int SMP_W = 16;
    localparam int EPS_W = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

    // Datapath widths, sized for SLICE_MAX up to 64
    localparam int SUM_W  = 22;   // running sum of samples
    localparam int SQS_W  = 37;   // running sum of squares
    localparam int NQ_W   = 43;   // n*Q and S*S
    localparam int DIVD_W = 50;   // divider dividend and quotient
    localparam int DVSR_W = 38;   // divider divisor and remainder
    localparam int ROOT_W = 32;   // square root result, Q8.24
    localparam int RAD_W  = 64;   // square root radicand
    localparam int SREM_W = 34;   // square root partial remainder
    localparam int DIFF_W = 24;   // n*x - S
    localparam int PROD_W = 39;   // scale * (n*x - S)
    localparam int Y_W    = 52;   // result before saturation
    localparam int CNT_W  = 6;

    localparam int DIV_STEPS  = DIVD_W;
    localparam int ROOT_STEPS = RAD_W / 2;

    localparam logic signed [Y_W-1:0] SAT_MAX = 52'sd32767;
    localparam logic signed [Y_W-1:0] SAT_MIN = -52'sd32768;

endpackage
`default_nettype wire

// File: design/instance_norm_slice.sv
`default_nettype none
// Instance normalisation of one (batch, channel) slice. Samples (Q8.8) arrive
// on the slave stream, one transaction each, and are held in a 64-entry
// sample memory while their sum and sum of squares are accumulated; tlast
// closes the slice, and the 64th sample closes it too. The closing
// transaction also carries the channel scale (Q4.12) and bias (Q8.8). The
// block then forms the population variance with a shared restoring divider,
// takes a bit-pair square root of (variance + epsilon) and emits every stored
// sample, in arrival order, as scale*(x - mean)/sqrt(var + eps) + bias,
// rounded half away from zero and saturated to 16 bits, with tlast on the
// final result. Only one item is in work at a time: s_axis_tready is high
// only while the block is idle. A sample that does not close the slice is
// accumulated and the block returns to idle. A closing sample runs the variance
// divide (50 steps), the root (32 steps) and then one 50-step divide per result;
// a result waits while m_axis_tready is held low. epsilon (Q16.16, reset value
// one LSB) is written through cfg_wr_en and cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.
module instance_norm_slice (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: variance_epsilon
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    // input samples
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // [15:0] sample_value, [31:16] channel_scale,
                                            // [47:32] channel_bias
    input  wire logic        s_axis_tlast,  // slice_end
    // normalised results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // [15:0] norm_value
    output logic             m_axis_tlast   // last_result
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ,
        ST_VAR_MUL,
        ST_VAR_LOAD,
        ST_VAR_DIV,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_DEN,
        ST_DIFF,
        ST_PROD,
        ST_OUT_LOAD,
        ST_OUT_DIV,
        ST_FIN,
        ST_OUT_WAIT,
        ST_RD_WAIT
    } state_t;

    state_t state_reg;

    // Sample memory
    logic signed [inorm_pkg::SMP_W-1:0] mem [inorm_pkg::SLICE_MAX];
    logic signed [inorm_pkg::SMP_W-1:0] rd_data_reg;

    // Slice accumulation
    logic [inorm_pkg::FILL_W-1:0]        fill_reg;
    logic signed [inorm_pkg::SUM_W-1:0]  sum_reg;
    logic [inorm_pkg::SQS_W-1:0]         sqs_reg;
    logic signed [inorm_pkg::SMP_W-1:0]  x_reg;
    logic signed [inorm_pkg::SMP_W-1:0]  scale_reg;
    logic signed [inorm_pkg::SMP_W-1:0]  bias_reg;
    logic                                close_reg;
    logic [inorm_pkg::EPS_W-1:0]         eps_reg;

    // Per-slice results
    logic [inorm_pkg::NQ_W-1:0]   nq_reg;
    logic [inorm_pkg::NQ_W-1:0]   ss_reg;
    logic [inorm_pkg::DVSR_W-1:0] den_reg;

    // Shared divider
    logic [inorm_pkg::DVSR_W-1:0] div_rem_reg;
    logic [inorm_pkg::DIVD_W-1:0] div_quo_reg;
    logic [inorm_pkg::DVSR_W-1:0] div_dvsr_reg;

    // Square root
    logic [inorm_pkg::SREM_W-1:0] sq_rem_reg;
    logic [inorm_pkg::ROOT_W-1:0] sq_root_reg;
    logic [inorm_pkg::RAD_W-1:0]  sq_rad_reg;

    logic [inorm_pkg::CNT_W-1:0]  step_reg;
    logic [inorm_pkg::ADDR_W-1:0] idx_reg;

    // Per-result datapath
    logic signed [inorm_pkg::DIFF_W-1:0] diff_reg;
    logic signed [inorm_pkg::PROD_W-1:0] prod_reg;

    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_last_reg;

    // ---------------------------------------------------------------
    // Combinational helpers
    // ---------------------------------------------------------------
    logic                                 in_fire;
    logic                                 in_close;
    logic [inorm_pkg::FILL_W-1:0]         fill_inc;
    logic signed [inorm_pkg::SMP_W-1:0]   in_sample;
    logic signed [31:0]                   sq_prod;
    logic [inorm_pkg::NQ_W:0]             nq_full;
    logic signed [inorm_pkg::NQ_W:0]      ss_full;
    logic [2*inorm_pkg::FILL_W-1:0]       nn_full;
    logic [inorm_pkg::NQ_W-1:0]           var_dividend;
    logic [31:0]                          v_sum;
    logic [30:0]                          v_val;
    logic [inorm_pkg::ROOT_W+inorm_pkg::FILL_W-1:0] den_full;
    logic signed [inorm_pkg::DIFF_W-1:0]  nx_prod;
    logic signed [inorm_pkg::DIFF_W-1:0]  diff_full;
    logic signed [inorm_pkg::PROD_W:0]    prod_full;
    logic [inorm_pkg::PROD_W-1:0]         prod_mag;
    logic [inorm_pkg::DIVD_W-1:0]         out_dividend;
    logic signed [inorm_pkg::Y_W-1:0]     q_signed;
    logic signed [inorm_pkg::Y_W-1:0]     y_full;
    logic [15:0]                          y_sat;
    logic                                 is_last;

    logic [inorm_pkg::DVSR_W:0]   div_shift;
    logic                         div_ge;
    logic [inorm_pkg::DVSR_W:0]   div_diff;
    logic [inorm_pkg::SREM_W+1:0] sq_shift;
    logic [inorm_pkg::SREM_W+1:0] sq_trial;
    logic                         sq_ge;
    logic [inorm_pkg::SREM_W+1:0] sq_diff;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_sample     = s_axis_tdata[15:0];
    assign fill_inc      = fill_reg + inorm_pkg::FILL_W'(1);
    assign in_close      = s_axis_tlast || (fill_inc == inorm_pkg::FILL_W'(inorm_pkg::SLICE_MAX));

    assign sq_prod  = x_reg * x_reg;
    assign nq_full  = fill_reg * sqs_reg;
    assign ss_full  = sum_reg * sum_reg;
    assign nn_full  = fill_reg * fill_reg;
    assign var_dividend = (nq_reg >= ss_reg) ? (nq_reg - ss_reg) : '0;

    // v = var + eps, with zero taken as one LSB
    assign v_sum = {1'b0, div_quo_reg[30:0]} + {16'd0, eps_reg};
    assign v_val = (v_sum[30:0] == 31'd0) ? 31'd1 : v_sum[30:0];

    assign den_full  = fill_reg * sq_root_reg;
    assign nx_prod   = $signed({1'b0, fill_reg}) * rd_data_reg;
    assign diff_full = nx_prod - inorm_pkg::DIFF_W'(sum_reg);
    assign prod_full = scale_reg * diff_reg;
    assign prod_mag  = prod_reg[inorm_pkg::PROD_W-1] ? inorm_pkg::PROD_W'(-prod_reg)
                                                     : inorm_pkg::PROD_W'(prod_reg);
    // |num| + den/2, num being scale*d*4096
    assign out_dividend = {prod_mag[37:0], 12'd0}
                        + inorm_pkg::DIVD_W'(den_reg[inorm_pkg::DVSR_W-1:1]);

    assign q_signed = $signed({2'b00, div_quo_reg});
    assign y_full   = (prod_reg[inorm_pkg::PROD_W-1] ? -q_signed : q_signed)
                    + inorm_pkg::Y_W'(bias_reg);
    assign y_sat    = (y_full > inorm_pkg::SAT_MAX) ? 16'h7FFF :
                      (y_full < inorm_pkg::SAT_MIN) ? 16'h8000 : y_full[15:0];
    assign is_last  = (inorm_pkg::FILL_W'(idx_reg) + inorm_pkg::FILL_W'(1) == fill_reg);

    // One restoring divide step
    assign div_shift = {div_rem_reg, div_quo_reg[inorm_pkg::DIVD_W-1]};
    assign div_ge    = (div_shift >= {1'b0, div_dvsr_reg});
    assign div_diff  = div_ge ? (div_shift - {1'b0, div_dvsr_reg}) : div_shift;

    // One bit-pair square root step
    assign sq_shift = {sq_rem_reg, sq_rad_reg[inorm_pkg::RAD_W-1 -: 2]};
    assign sq_trial = {2'b00, sq_root_reg, 2'b01};
    assign sq_ge    = (sq_shift >= sq_trial);
    assign sq_diff  = sq_ge ? (sq_shift - sq_trial) : sq_shift;

    // ---------------------------------------------------------------
    // Sample memory: one write port, one registered read port
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mem[fill_reg[inorm_pkg::ADDR_W-1:0]] <= in_sample;
        end
        rd_data_reg <= mem[idx_reg];
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            sum_reg       <= '0;
            sqs_reg       <= '0;
            eps_reg       <= inorm_pkg::EPS_RESET;
            close_reg     <= 1'b0;
            step_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            out_data_reg  <= '0;
            x_reg         <= '0;
            scale_reg     <= '0;
            bias_reg      <= '0;
            nq_reg        <= '0;
            ss_reg        <= '0;
            den_reg       <= '0;
            div_rem_reg   <= '0;
            div_quo_reg   <= '0;
            div_dvsr_reg  <= '0;
            sq_rem_reg    <= '0;
            sq_root_reg   <= '0;
            sq_rad_reg    <= '0;
            diff_reg      <= '0;
            prod_reg      <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                eps_reg <= cfg_wr_data;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        x_reg     <= in_sample;
                        scale_reg <= s_axis_tdata[31:16];
                        bias_reg  <= s_axis_tdata[47:32];
                        close_reg <= in_close;
                        fill_reg  <= fill_inc;
                        sum_reg   <= sum_reg + inorm_pkg::SUM_W'(in_sample);
                        state_reg <= ST_SQ;
                    end
                end
                ST_SQ:
                begin
                    sqs_reg   <= sqs_reg + inorm_pkg::SQS_W'(unsigned'(sq_prod));
                    state_reg <= close_reg ? ST_VAR_MUL : ST_IDLE;
                end
                ST_VAR_MUL:
                begin
                    nq_reg    <= nq_full[inorm_pkg::NQ_W-1:0];
                    ss_reg    <= ss_full[inorm_pkg::NQ_W-1:0];
                    state_reg <= ST_VAR_LOAD;
                end
                ST_VAR_LOAD:
                begin
                    div_rem_reg  <= '0;
                    div_quo_reg  <= inorm_pkg::DIVD_W'(var_dividend);
                    div_dvsr_reg <= inorm_pkg::DVSR_W'(nn_full);
                    step_reg     <= '0;
                    state_reg    <= ST_VAR_DIV;
                end
                ST_VAR_DIV:
                begin
                    div_rem_reg <= div_diff[inorm_pkg::DVSR_W-1:0];
                    div_quo_reg <= {div_quo_reg[inorm_pkg::DIVD_W-2:0], div_ge};
                    step_reg    <= step_reg + inorm_pkg::CNT_W'(1);
                    if (step_reg == inorm_pkg::CNT_W'(inorm_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_ROOT_LOAD;
                    end
                end
                ST_ROOT_LOAD:
                begin
                    // radicand is v * 2^32, giving the root in Q8.24
                    sq_rad_reg  <= {1'b0, v_val, 32'd0};
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    step_reg    <= '0;
                    idx_reg     <= '0;
                    state_reg   <= ST_ROOT;
                end
                ST_ROOT:
                begin
                    sq_rem_reg  <= sq_diff[inorm_pkg::SREM_W-1:0];
                    sq_root_reg <= {sq_root_reg[inorm_pkg::ROOT_W-2:0], sq_ge};
                    sq_rad_reg  <= {sq_rad_reg[inorm_pkg::RAD_W-3:0], 2'b00};
                    step_reg    <= step_reg + inorm_pkg::CNT_W'(1);
                    if (step_reg == inorm_pkg::CNT_W'(inorm_pkg::ROOT_STEPS - 1))
                    begin
                        state_reg <= ST_DEN;
                    end
                end
                ST_DEN:
                begin
                    den_reg   <= den_full[inorm_pkg::DVSR_W-1:0];
                    state_reg <= ST_DIFF;
                end
                ST_DIFF:
                begin
                    diff_reg  <= diff_full;
                    state_reg <= ST_PROD;
                end
                ST_PROD:
                begin
                    prod_reg  <= prod_full[inorm_pkg::PROD_W-1:0];
                    state_reg <= ST_OUT_LOAD;
                end
                ST_OUT_LOAD:
                begin
                    div_rem_reg  <= '0;
                    div_quo_reg  <= out_dividend;
                    div_dvsr_reg <= den_reg;
                    step_reg     <= '0;
                    state_reg    <= ST_OUT_DIV;
                end
                ST_OUT_DIV:
                begin
                    div_rem_reg <= div_diff[inorm_pkg::DVSR_W-1:0];
                    div_quo_reg <= {div_quo_reg[inorm_pkg::DIVD_W-2:0], div_ge};
                    step_reg    <= step_reg + inorm_pkg::CNT_W'(1);
                    if (step_reg == inorm_pkg::CNT_W'(inorm_pkg::DIV_STEPS - 1))
                    begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN:
                begin
                    out_data_reg  <= y_sat;
                    out_last_reg  <= is_last;
                    out_valid_reg <= 1'b1;
                    state_reg     <= ST_OUT_WAIT;
                end
                ST_OUT_WAIT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            // slice done: drop the accumulators
                            fill_reg  <= '0;
                            sum_reg   <= '0;
                            sqs_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + inorm_pkg::ADDR_W'(1);
                            state_reg <= ST_RD_WAIT;
                        end
                    end
                end
                ST_RD_WAIT:
                begin
                    state_reg <= ST_DIFF;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tlast  = out_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input taken while a result is pending");

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= inorm_pkg::FILL_W'(inorm_pkg::SLICE_MAX))
        else $error("fill count beyond store depth");

    a_var_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROOT_LOAD) |-> (div_quo_reg[inorm_pkg::DIVD_W-1:31] == '0))
        else $error("variance out of range");

    a_root_min: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DEN) |-> (sq_root_reg[inorm_pkg::ROOT_W-1:16] != '0))
        else $error("square root below one");

    a_slice_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (fill_reg == '0 && sum_reg == '0 && s_axis_tready))
        else $error("slice state not cleared after last result");

endmodule
`default_nettype wire

// File: tb/sv/instance_norm_slice_test.sv
`timescale 1ns / 100ps
`default_nettype none
module instance_norm_slice_test;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;   // [15:0] sample, [31:16] scale, [47:32] bias
    logic        s_axis_tlast;   // slice_end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // [15:0] norm_value
    logic        m_axis_tlast;   // last_result

    instance_norm_slice dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    typedef struct packed {
        logic [15:0] norm_value;
        logic        last_result;
    } norm_result_t;

    // Predictor state: slice contents, running sum and epsilon
    logic signed [15:0] slice_samples[inorm_pkg::SLICE_MAX];
    int unsigned        slice_fill;
    longint             slice_sum;
    logic [15:0]        eps_q16;

    norm_result_t pending_norms[$];
    int  mismatch_count;
    int  items_sent;
    int  results_seen;
    int  slices_closed;
    bit  idle_enabled;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Backstop: ends a run that hangs on a handshake
    initial
    begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
        mismatch_count++;
    endtask

    // Integer square root, floor, bit-pair method
    function automatic longint unsigned floor_sqrt(input longint unsigned radicand);
        longint unsigned res;
        longint unsigned bitval;
        res    = 0;
        bitval = 64'd1 << 62;
        while (bitval > radicand)
            bitval >>= 2;
        while (bitval != 0)
        begin
            if (radicand >= res + bitval)
            begin
                radicand -= res + bitval;
                res = (res >> 1) + bitval;
            end
            else
                res >>= 1;
            bitval >>= 2;
        end
        return res;
    endfunction

    // Store one sample; on slice close, queue the normalised results
    task automatic predict_sample(input logic signed [15:0] x, input logic signed [15:0] scale,
                                  input logic signed [15:0] bias, input logic close);
        longint          n, sq_sum, dev, num, y;
        longint unsigned nq, ss, var_q, v, root, den, mag, qq;
        norm_result_t    r;
        if (slice_fill >= inorm_pkg::SLICE_MAX)
            slice_fill = 0;
        slice_samples[slice_fill] = x;
        slice_fill++;
        slice_sum += x;
        if (!close && slice_fill < inorm_pkg::SLICE_MAX)
            return;
        n = slice_fill;
        sq_sum = 0;
        for (int i = 0; i < n; i++)
            sq_sum += longint'(slice_samples[i]) * longint'(slice_samples[i]);
        nq = n * sq_sum;
        ss = slice_sum * slice_sum;
        var_q = (nq >= ss) ? (nq - ss) / (n * n) : 0;
        v = var_q + eps_q16;
        if (v == 0)
            v = 1;
        root = floor_sqrt(v << 32);
        den = n * root;
        for (int i = 0; i < n; i++)
        begin
            dev = n * longint'(slice_samples[i]) - slice_sum;
            num = longint'(scale) * dev * 4096;
            mag = (num < 0) ? -num : num;
            qq = (mag + den / 2) / den;
            y = (num < 0) ? -longint'(qq) : longint'(qq);
            y += bias;
            if (y > 32767)
                y = 32767;
            if (y < -32768)
                y = -32768;
            r.norm_value  = y[15:0];
            r.last_result = (i + 1 == n);
            pending_norms.push_back(r);
        end
        slice_fill = 0;
        slice_sum = 0;
        slices_closed++;
    endtask

    function automatic bit idle_now();
        return idle_enabled && ($urandom_range(99) < 31);
    endfunction

    // Send one sample transaction, with a random gap ahead of it
    task automatic send_sample(input logic [15:0] x, input logic [15:0] scale,
                               input logic [15:0] bias, input logic close);
        while (idle_now())
            @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {bias, scale, x};
        s_axis_tlast  = close;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_sample(x, scale, bias, close);
        items_sent++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Receiver: stall at random, compare each accepted result with the oldest expectation
    initial
    begin
        norm_result_t want;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            m_axis_tready = !idle_now();
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_norms.size() == 0)
                begin
                    report_mismatch("unexpected result", m_axis_tdata, 0);
                end
                else
                begin
                    want = pending_norms.pop_front();
                    if (m_axis_tdata !== want.norm_value)
                        report_mismatch("norm_value", $signed(m_axis_tdata),
                                        $signed(want.norm_value));
                    if (m_axis_tlast !== want.last_result)
                        report_mismatch("last_result", m_axis_tlast, want.last_result);
                end
                results_seen++;
            end
        end
    end

    // Drain outstanding results, then allow the block to settle before a register write
    task automatic wait_drained();
        while (pending_norms.size() != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    task automatic write_epsilon(input logic [15:0] value);
        wait_drained();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        eps_q16     = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    task automatic send_random_slice(input int len);
        for (int i = 0; i < len; i++)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), (i == len - 1));
    endtask

    // Directed: extremes, single-sample slice, zero variance with zero epsilon
    task automatic test_directed();
        send_sample(16'h8000, 16'h7FFF, 16'h7FFF, 1'b1);                // one sample, var 0
        send_sample(16'h7FFF, 16'h1000, 16'h0000, 1'b0);
        send_sample(16'h8000, 16'h8000, 16'h8000, 1'b1);                // widest spread
        send_sample(16'h0100, 16'h1000, 16'h0000, 1'b0);
        send_sample(16'hFF00, 16'h7FFF, 16'h8000, 1'b1);                // saturation at the negative end
        write_epsilon(16'h0000);
        send_sample(16'h1234, 16'h1000, 16'h0100, 1'b0);
        send_sample(16'h1234, 16'h1000, 16'h0100, 1'b1);                // v taken as one
        send_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
        write_epsilon(16'hFFFF);
        send_sample(16'h0001, 16'h1000, 16'h0000, 1'b0);
        send_sample(16'h0000, 16'h8000, 16'h7FFF, 1'b1);
    endtask

    task automatic test_full_store();
        write_epsilon(16'h0001);
        for (int i = 0; i < inorm_pkg::SLICE_MAX; i++)
            send_sample(16'($urandom), 16'($urandom), 16'($urandom), 1'b0);  // 64th closes
        send_random_slice(3);
    endtask

    task automatic test_random(input int budget);
        int len;
        while (items_sent < budget)
        begin
            if ($urandom_range(9) == 0)
                write_epsilon($urandom_range(3) == 0 ? 16'(0) : 16'($urandom));
            if ($urandom_range(7) == 0)
                len = $urandom_range(inorm_pkg::SLICE_MAX, 40);
            else
                len = $urandom_range(12, 1);
            // sometimes small-range samples so that mid-range outputs dominate
            for (int i = 0; i < len; i++)
                send_sample($urandom_range(1) ? 16'($urandom) : 16'($urandom_range(1023) - 512),
                            16'($urandom), 16'($urandom), i == len - 1);
        end
    endtask

    task automatic test_steady();
        idle_enabled = 1'b0;                                             // no gaps at all
        test_random(items_sent + 60);
        idle_enabled = 1'b1;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        slice_fill = 0;
        slice_sum = 0;
        eps_q16 = inorm_pkg::EPS_RESET;
        mismatch_count = 0;
        items_sent = 0;
        results_seen = 0;
        slices_closed = 0;
        idle_enabled = 1'b1;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_full_store();
        test_steady();
        test_random(330);
        write_epsilon(16'h0001);
        $display("covered %0d samples in %0d slices, %0d results checked",
                 items_sent, slices_closed, results_seen);
        if (mismatch_count == 0 && pending_norms.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire
